// ----- hdl/sliq_pkg.sv -----
`timescale 1ns / 1ps

package sliq_pkg;

  // Channels that the configuration registers cover.
  localparam int RegChans = 12;

  // Configuration port geometry: 64-bit data, registers on 8-byte steps.
  localparam int ApbDataW = 64;
  localparam int ApbAddrW = 6;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_ACTION   = 3'd1,
    REG_FUNCTION = 3'd2,
    REG_HOMING   = 3'd3,
    REG_PROBING  = 3'd4,
    REG_LOCKOUT  = 3'd5
  } reg_idx_e;

  // Item operation codes; code 3 behaves as a tick.
  typedef enum logic [1:0] {
    OP_RESYNC = 2'd0,
    OP_CHANGE = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // Stored channel level.
  localparam logic [1:0] LVL_INACTIVE = 2'd0;
  localparam logic [1:0] LVL_ACTIVE   = 2'd1;
  localparam logic [1:0] LVL_DISABLED = 2'd2;

  // Channel mode codes (2 and 3 mean disabled).
  localparam logic [1:0] MODE_ACTIVE_LOW  = 2'd0;
  localparam logic [1:0] MODE_ACTIVE_HIGH = 2'd1;

  // Configured action per channel.
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_STOP      = 3'd1;
  localparam logic [2:0] ACT_FAST_STOP = 3'd2;
  localparam logic [2:0] ACT_HALT      = 3'd3;
  localparam logic [2:0] ACT_ALARM     = 3'd4;
  localparam logic [2:0] ACT_SHUTDOWN  = 3'd5;
  localparam logic [2:0] ACT_PANIC     = 3'd6;
  localparam logic [2:0] ACT_RESET     = 3'd7;

  // Configured function per channel.
  localparam logic [2:0] FN_NONE      = 3'd0;
  localparam logic [2:0] FN_LIMIT     = 3'd1;
  localparam logic [2:0] FN_INTERLOCK = 3'd2;
  localparam logic [2:0] FN_SHUTDOWN  = 3'd3;

  // Reported sensing events.
  localparam logic [1:0] SENSE_NONE   = 2'd0;
  localparam logic [1:0] SENSE_HOMING = 2'd1;
  localparam logic [1:0] SENSE_PROBE  = 2'd2;

  // Reported action events.
  localparam logic [2:0] AEV_NONE     = 3'd0;
  localparam logic [2:0] AEV_FEEDHOLD = 3'd1;
  localparam logic [2:0] AEV_HALT     = 3'd2;
  localparam logic [2:0] AEV_ALARM    = 3'd3;
  localparam logic [2:0] AEV_SHUTDOWN = 3'd4;
  localparam logic [2:0] AEV_PANIC    = 3'd5;
  localparam logic [2:0] AEV_RESET    = 3'd6;

  // Reported function events.
  localparam logic [2:0] FEV_NONE          = 3'd0;
  localparam logic [2:0] FEV_LIMIT         = 3'd1;
  localparam logic [2:0] FEV_SHUTDOWN      = 3'd2;
  localparam logic [2:0] FEV_INTERLOCK_OFF = 3'd3;
  localparam logic [2:0] FEV_INTERLOCK_ON  = 3'd4;

  // Register reset values.
  localparam logic [23:0] ModeReset    = 24'hAAAAAA;
  localparam logic [15:0] LockoutReset = 16'd50;

  // Configuration as seen by the qualifier logic.
  typedef struct packed {
    logic [23:0] mode;
    logic [35:0] action;
    logic [35:0] func;
    logic [11:0] homing;
    logic [11:0] probing;
    logic [15:0] lockout;
  } cfg_t;

endpackage

// ----- hdl/sliq_regs.sv -----
`timescale 1ns / 1ps

module sliq_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sliq_pkg::ApbAddrW-1:0]    paddr,
  input  logic [sliq_pkg::ApbDataW-1:0]    pwdata,
  output logic [sliq_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready,
  output sliq_pkg::cfg_t                   cfg_o
);
  import sliq_pkg::*;

  cfg_t     cfg_q;
  cfg_t     cfg_d;
  reg_idx_e reg_idx;
  logic     wr_en;

  assign reg_idx = reg_idx_e'(paddr[ApbAddrW-1:3]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  // Write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_MODE:     cfg_d.mode    = pwdata[23:0];
        REG_ACTION:   cfg_d.action  = pwdata[35:0];
        REG_FUNCTION: cfg_d.func    = pwdata[35:0];
        REG_HOMING:   cfg_d.homing  = pwdata[11:0];
        REG_PROBING:  cfg_d.probing = pwdata[11:0];
        REG_LOCKOUT:  cfg_d.lockout = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= ModeReset;
      cfg_q.action  <= '0;
      cfg_q.func    <= '0;
      cfg_q.homing  <= '0;
      cfg_q.probing <= '0;
      cfg_q.lockout <= LockoutReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (reg_idx)
      REG_MODE:     prdata = ApbDataW'(cfg_q.mode);
      REG_ACTION:   prdata = ApbDataW'(cfg_q.action);
      REG_FUNCTION: prdata = ApbDataW'(cfg_q.func);
      REG_HOMING:   prdata = ApbDataW'(cfg_q.homing);
      REG_PROBING:  prdata = ApbDataW'(cfg_q.probing);
      REG_LOCKOUT:  prdata = ApbDataW'(cfg_q.lockout);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hdl/switch_input_lockout_event_qualifier_unit.sv -----
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+---------------------------------------
// in        | sink      | in_valid_i / in_stall_o  | operation_i, channel_i, pin_level_i
// out       | source    | out_valid_o / out_stall_i| channel_out_o, level_o, changed_o, ...
// config    | APB slave | psel, penable, pready    | paddr, pwdata, prdata (64-bit)
//
// Every item gives one result once accepted: it waits in the input register, then
// passes through the qualifier logic into the result register.
// One item per cycle is sustained while the output is not stalled; channel state
// is updated as the result is registered, so the next item already sees it.
// Reset leaves every channel disabled with no lockout running.
// A stalled result holds; the input register still takes one more item.

module switch_input_lockout_event_qualifier_unit #(
  parameter int CHANNELS      = 12,
  parameter int LOCKOUT_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Input items
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [1:0]                       operation_i,
  input  logic [3:0]                       channel_i,
  input  logic                             pin_level_i,
  // Result items
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [3:0]                       channel_out_o,
  output logic [1:0]                       level_o,
  output logic                             changed_o,
  output logic                             edge_res_o,
  output logic [1:0]                       sensing_event_o,
  output logic [2:0]                       action_event_o,
  output logic [2:0]                       function_event_o,
  output logic                             report_request_o,
  // Configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sliq_pkg::ApbAddrW-1:0]    paddr,
  input  logic [sliq_pkg::ApbDataW-1:0]    pwdata,
  output logic [sliq_pkg::ApbDataW-1:0]    prdata,
  output logic                             pready
);
  import sliq_pkg::*;

  localparam int IdxW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ActiveChans = (CHANNELS < RegChans) ? CHANNELS : RegChans;
  localparam logic [32:0] LockMax = (33'd1 << LOCKOUT_WIDTH) - 33'd1;

  cfg_t cfg;

  sliq_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline control.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance, in_accept, work;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign work       = advance && s1_valid_q;

  assign s1_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_q);
  assign out_valid_d = advance ? s1_valid_q : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register.
  logic [1:0] s1_op_q;
  logic [3:0] s1_ch_q;
  logic       s1_pin_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q  <= operation_i;
      s1_ch_q  <= channel_i;
      s1_pin_q <= pin_level_i;
    end
  end

  // Per-channel state.
  logic [1:0]               chan_state_q [CHANNELS];
  logic [1:0]               chan_state_d [CHANNELS];
  logic [LOCKOUT_WIDTH-1:0] lock_left_q  [CHANNELS];
  logic [LOCKOUT_WIDTH-1:0] lock_left_d  [CHANNELS];

  // Qualifier decode for the item in the input register.
  logic [IdxW-1:0]          ch_idx;
  logic                     in_range;
  logic [1:0]               mode;
  logic                     enabled;
  logic [1:0]               corr;
  logic [1:0]               cur_state;
  logic [LOCKOUT_WIDTH-1:0] cur_lock;
  logic [2:0]               act;
  logic [2:0]               fn;
  logic                     homing;
  logic                     probing;
  logic                     leading;
  logic [32:0]              ticks_ext;
  logic [LOCKOUT_WIDTH-1:0] lock_load;
  logic                     is_tick;

  assign ch_idx    = s1_ch_q[IdxW-1:0];
  assign in_range  = 5'(s1_ch_q) < 5'(ActiveChans);
  assign mode      = 2'(cfg.mode >> {s1_ch_q, 1'b0});
  assign enabled   = (mode == MODE_ACTIVE_LOW) || (mode == MODE_ACTIVE_HIGH);
  assign corr      = {1'b0, s1_pin_q ^ ~mode[0]};
  assign cur_state = in_range ? chan_state_q[ch_idx] : LVL_DISABLED;
  assign cur_lock  = in_range ? lock_left_q[ch_idx] : '0;
  assign act       = 3'(cfg.action >> (6'(s1_ch_q) * 6'd3));
  assign fn        = 3'(cfg.func >> (6'(s1_ch_q) * 6'd3));
  assign homing    = 1'(cfg.homing >> s1_ch_q);
  assign probing   = 1'(cfg.probing >> s1_ch_q);
  assign leading   = (corr == LVL_ACTIVE);
  assign ticks_ext = 33'(cfg.lockout);
  assign lock_load = (ticks_ext > LockMax) ? LockMax[LOCKOUT_WIDTH-1:0]
                                           : ticks_ext[LOCKOUT_WIDTH-1:0];
  assign is_tick   = (s1_op_q != OP_RESYNC) && (s1_op_q != OP_CHANGE);

  // Result fields and the channel state update for this item.
  logic [3:0] r_ch;
  logic [1:0] r_level;
  logic       r_changed, r_edge, r_report;
  logic [1:0] r_sense;
  logic [2:0] r_act, r_fn;
  logic       wr_state, wr_lock;
  logic [1:0] new_state;
  logic [LOCKOUT_WIDTH-1:0] new_lock;

  always_comb begin
    r_ch      = 4'd0;
    r_level   = LVL_INACTIVE;
    r_changed = 1'b0;
    r_edge    = 1'b0;
    r_sense   = SENSE_NONE;
    r_act     = AEV_NONE;
    r_fn      = FEV_NONE;
    r_report  = 1'b0;
    wr_state  = 1'b0;
    wr_lock   = 1'b0;
    new_state = LVL_DISABLED;
    new_lock  = '0;
    if (!is_tick) begin
      r_ch = s1_ch_q;
      if (!in_range) begin
        r_level = LVL_DISABLED;
      end else if (!enabled) begin
        r_level   = LVL_DISABLED;
        wr_state  = 1'b1;
        new_state = LVL_DISABLED;
      end else if (s1_op_q == OP_RESYNC) begin
        r_level   = corr;
        wr_state  = 1'b1;
        new_state = corr;
        wr_lock   = 1'b1;
        new_lock  = '0;
      end else if ((cur_lock != '0) || (cur_state == corr)) begin
        r_level = cur_state;
      end else begin
        // A real change: restart the lockout and report the edge.
        wr_state  = 1'b1;
        new_state = corr;
        wr_lock   = 1'b1;
        new_lock  = lock_load;
        r_level   = corr;
        r_changed = 1'b1;
        r_edge    = !leading;
        if (homing) begin
          r_sense = leading ? SENSE_HOMING : SENSE_NONE;
        end else if (probing) begin
          r_sense = SENSE_PROBE;
        end else begin
          r_report = 1'b1;
          if (leading) begin
            case (act)
              ACT_STOP, ACT_FAST_STOP: r_act = AEV_FEEDHOLD;
              ACT_HALT:                r_act = AEV_HALT;
              ACT_ALARM:               r_act = AEV_ALARM;
              ACT_SHUTDOWN:            r_act = AEV_SHUTDOWN;
              ACT_PANIC:               r_act = AEV_PANIC;
              ACT_RESET:               r_act = AEV_RESET;
              default:                 r_act = AEV_NONE;
            endcase
            case (fn)
              FN_LIMIT:     r_fn = FEV_LIMIT;
              FN_SHUTDOWN:  r_fn = FEV_SHUTDOWN;
              FN_INTERLOCK: r_fn = FEV_INTERLOCK_OFF;
              default:      r_fn = FEV_NONE;
            endcase
          end else if (fn == FN_INTERLOCK) begin
            r_fn = FEV_INTERLOCK_ON;
          end
        end
      end
    end
  end

  // Next state of every channel: ticks count all running lockouts down.
  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      chan_state_d[c] = chan_state_q[c];
      lock_left_d[c]  = lock_left_q[c];
      if (work) begin
        if (is_tick) begin
          if (lock_left_q[c] != '0) begin
            lock_left_d[c] = lock_left_q[c] - LOCKOUT_WIDTH'(1);
          end
        end else if (in_range && (ch_idx == IdxW'(c))) begin
          if (wr_state) begin
            chan_state_d[c] = new_state;
          end
          if (wr_lock) begin
            lock_left_d[c] = new_lock;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        chan_state_q[c] <= LVL_DISABLED;
        lock_left_q[c]  <= '0;
      end
    end else begin
      chan_state_q <= chan_state_d;
      lock_left_q  <= lock_left_d;
    end
  end

  // Result register.
  logic [3:0] channel_out_q;
  logic [1:0] level_q;
  logic       changed_q, edge_res_q, report_q;
  logic [1:0] sensing_q;
  logic [2:0] action_q, function_q;

  always_ff @(posedge clk_i) begin
    if (work) begin
      channel_out_q <= r_ch;
      level_q       <= r_level;
      changed_q     <= r_changed;
      edge_res_q    <= r_edge;
      sensing_q     <= r_sense;
      action_q      <= r_act;
      function_q    <= r_fn;
      report_q      <= r_report;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_out_o    = channel_out_q;
  assign level_o          = level_q;
  assign changed_o        = changed_q;
  assign edge_res_o       = edge_res_q;
  assign sensing_event_o  = sensing_q;
  assign action_event_o   = action_q;
  assign function_event_o = function_q;
  assign report_request_o = report_q;

`ifndef NO_ASSERTIONS
  // A real change never reports a disabled level.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && changed_o |-> level_o != LVL_DISABLED)
    else $error("changed result with disabled level");

  // The edge direction only means something on a real change.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_res_o |-> changed_o)
    else $error("edge reported without a change");

  // Homing and probing hits suppress actions, functions and reports.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (sensing_event_o != SENSE_NONE) |->
      (action_event_o == AEV_NONE) && (function_event_o == FEV_NONE) && !report_request_o)
    else $error("sensing hit together with other events");

  // The input side stalls only behind a held result and a full input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i && s1_valid_q)
    else $error("input stalled without backpressure");

  // A held result keeps the input register full state unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !advance |=> s1_valid_q)
    else $error("item lost from input register");
`endif

endmodule
